/* hw/rtl/flsp_pkg.sv */
`timescale 1ns / 1ps
package flsp_pkg;

	localparam int LOG_FRAC_BITS = 20;
	localparam longint LOG2E_Q30 = 64'd1549082005;
	localparam int PHI_CENTER_Q16 = 70451;
	localparam logic [23:0] SPEED_MAX = 24'hFFFFFF;

	// configuration register indexes
	localparam logic [2:0] REG_REF_SPEED  = 3'd0;
	localparam logic [2:0] REG_PHI_EXP    = 3'd1;
	localparam logic [2:0] REG_GAUSS      = 3'd2;
	localparam logic [2:0] REG_RESIDUAL   = 3'd3;
	localparam logic [2:0] REG_TEMP_EXP   = 3'd4;
	localparam logic [2:0] REG_PRESS_EXP  = 3'd5;

	// special-case flags that ride along with a request
	typedef struct packed {
		logic zero;
		logic inf;
		logic tu_skip;
		logic p_skip;
	} spec_t;

	// log2 table entry: log2(1 + i/2^b) in Q20, built by repeated squaring
	function automatic longint unsigned lt_entry(int b, int i);
		longint unsigned x;
		longint unsigned k;
		k = 0;
		x = (64'd1 << 30) + (longint'(i) << (30 - b));
		if (i == (1 << b)) begin
			return 64'd1 << 20;
		end
		for (int j = 0; j <= 20; j++) begin
			x = (x * x) >> 30;
			k = k << 1;
			if (x >= (64'd1 << 31)) begin
				x = x >> 1;
				k = k | 64'd1;
			end
		end
		return (k + 64'd1) >> 1;
	endfunction

	function automatic longint unsigned isqrt64(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		longint unsigned rem;
		res = 0;
		bitv = 64'd1 << 62;
		rem = v;
		for (int k = 0; k < 32; k++) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// exp2 table entry: 2^(i/2^b) in Q30, product of successive square roots
	function automatic longint unsigned et_entry(int b, int i);
		longint unsigned roots [0:10];
		longint unsigned m;
		m = 64'd1 << 30;
		if (i == (1 << b)) begin
			return 64'd1 << 31;
		end
		roots[0] = 64'd1 << 31;
		for (int j = 1; j <= 10; j++) begin
			roots[j] = isqrt64(roots[j-1] << 30);
		end
		for (int j = 0; j < b; j++) begin
			if (((i >> j) & 1) != 0) begin
				m = (m * roots[b-j] + (64'd1 << 29)) >> 30;
			end
		end
		return m;
	endfunction

	// log2 of a constant in Q20, same interpolation as the hardware
	function automatic longint log2_const(int b, longint unsigned v, int q);
		int n;
		longint unsigned u;
		longint unsigned idx;
		longint unsigned rem;
		longint unsigned d;
		n = 0;
		for (int k = 0; k < 63; k++) begin
			if (((v >> k) & 64'd1) != 0) begin
				n = k;
			end
		end
		u = (v << (32 - n)) & 64'hFFFF_FFFF;
		idx = u >> (32 - b);
		rem = u & ((64'd1 << (32 - b)) - 64'd1);
		d = lt_entry(b, int'(idx) + 1) - lt_entry(b, int'(idx));
		return longint'(n - q) * (64'sd1 << 20)
			+ longint'(lt_entry(b, int'(idx)) + ((d * rem) >> (32 - b)));
	endfunction

endpackage

/* hw/rtl/flsp_log2.sv */
`timescale 1ns / 1ps
module flsp_log2 #(
	parameter int B    = 6,
	parameter int W_IN = 24,
	parameter int Q    = 0
) (
	input  logic               clk,
	input  logic               en,
	input  logic [W_IN-1:0]    v,
	output logic signed [31:0] log_s2
);

	localparam int N  = 1 << B;
	localparam int SH = 32 - B;
	localparam int NW = $clog2(W_IN);

	logic [20:0] lt_rom [0:N];

	generate
		for (genvar g = 0; g <= N; g++) begin : g_lt
			assign lt_rom[g] = 21'(flsp_pkg::lt_entry(B, g));
		end
	endgenerate

	logic [NW-1:0]      msb;
	logic [W_IN+31:0]   wide;
	logic [31:0]        u;
	logic [B:0]         ia;
	logic [B:0]         ib;

	logic [NW-1:0]      msb_s1;
	logic [SH-1:0]      rem_s1;
	logic [20:0]        lt0_s1;
	logic [20:0]        lt1_s1;

	logic [20:0]        delta;
	logic [20+SH:0]     prod;

	// find the leading one and left-align the bits below it
	always_comb begin
		msb = '0;
		for (int k = 0; k < W_IN; k++) begin
			if (v[k]) begin
				msb = NW'(k);
			end
		end
	end

	assign wide = {v, 32'b0} >> msb;
	assign u    = wide[31:0];
	assign ia   = {1'b0, u[31:SH]};
	assign ib   = ia + (B+1)'(1);

	// table lookup stage
	always_ff @(posedge clk) begin
		if (en) begin
			msb_s1 <= msb;
			rem_s1 <= u[SH-1:0];
			lt0_s1 <= lt_rom[ia];
			lt1_s1 <= lt_rom[ib];
		end
	end

	// interpolate and add the integer part
	assign delta = lt1_s1 - lt0_s1;
	assign prod  = (21+SH)'(delta) * (21+SH)'(rem_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			log_s2 <= 32'((int'(msb_s1) - Q) * (1 << flsp_pkg::LOG_FRAC_BITS))
				+ 32'(lt0_s1) + 32'(prod[20+SH:SH]);
		end
	end

endmodule

/* hw/rtl/flsp_exp2.sv */
`timescale 1ns / 1ps
module flsp_exp2 #(
	parameter int B = 6
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [41:0] e,
	output logic [31:0]        m_s2,
	output logic signed [21:0] ip_s2
);

	localparam int N  = 1 << B;
	localparam int RS = 20 - B;

	logic [31:0] et_rom [0:N];

	generate
		for (genvar g = 0; g <= N; g++) begin : g_et
			assign et_rom[g] = 32'(flsp_pkg::et_entry(B, g));
		end
	endgenerate

	logic [B:0]         ja;
	logic [B:0]         jb;
	logic signed [21:0] ip_s1;
	logic [RS-1:0]      r_s1;
	logic [31:0]        et0_s1;
	logic [31:0]        et1_s1;
	logic [31:0]        delta;
	logic [31+RS:0]     prod;

	assign ja = {1'b0, e[19:RS]};
	assign jb = ja + (B+1)'(1);

	// split integer and fraction, read the table
	always_ff @(posedge clk) begin
		if (en) begin
			ip_s1  <= e[41:20];
			r_s1   <= e[RS-1:0];
			et0_s1 <= et_rom[ja];
			et1_s1 <= et_rom[jb];
		end
	end

	// interpolate the mantissa
	assign delta = et1_s1 - et0_s1;
	assign prod  = (32+RS)'(delta) * (32+RS)'(r_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			ip_s2 <= ip_s1;
			m_s2  <= et0_s1 + prod[31+RS:RS];
		end
	end

endmodule

/* hw/rtl/laminar_flame_speed_eval_core.sv */
`timescale 1ns / 1ps
// An accepted request moves through the stage registers in order; out_valid is the valid bit of the last stage.
// Throughput: one request per cycle; a stall on out_ready freezes all stages at once.
// Depth is set by the chain LOD/table -> interpolate -> exponent multiply -> sum
// -> exp2 table -> interpolate -> round/shift.
// Reset: valid bits clear, configuration registers load their default values.
module laminar_flame_speed_eval_core #(
	parameter int LOG_TABLE_BITS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [23:0] pressure,
	input  logic [15:0] unburnt_temp,
	input  logic [15:0] equiv_ratio,
	input  logic [15:0] residual_frac,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] flame_speed,
	output logic        saturated,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	localparam longint LOG_4800   = flsp_pkg::log2_const(LOG_TABLE_BITS, 64'd4800, 4);
	localparam longint LOG_101300 = flsp_pkg::log2_const(LOG_TABLE_BITS, 64'd101300, 0);

	// configuration registers
	logic [23:0]        ref_speed_q;
	logic signed [15:0] phi_exponent_q;
	logic signed [15:0] gauss_width_q;
	logic [15:0]        residual_factor_q;
	logic signed [15:0] temp_exponent_q;
	logic signed [15:0] press_exponent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_speed_q       <= 24'd65536;
			phi_exponent_q    <= 16'sd4096;
			gauss_width_q     <= 16'sd4096;
			residual_factor_q <= 16'd0;
			temp_exponent_q   <= 16'sd8192;
			press_exponent_q  <= 16'sd0;
		end else if (cfg_we) begin
			case (cfg_index)
				flsp_pkg::REG_REF_SPEED: ref_speed_q       <= cfg_data;
				flsp_pkg::REG_PHI_EXP:   phi_exponent_q    <= cfg_data[15:0];
				flsp_pkg::REG_GAUSS:     gauss_width_q     <= cfg_data[15:0];
				flsp_pkg::REG_RESIDUAL:  residual_factor_q <= cfg_data[15:0];
				flsp_pkg::REG_TEMP_EXP:  temp_exponent_q   <= cfg_data[15:0];
				flsp_pkg::REG_PRESS_EXP: press_exponent_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// pipeline control: the whole pipe advances together
	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	assign en       = !vld_s8 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8} <= '0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// stage 1: capture, residual product, squared deviation of phi
	logic [23:0]        p_s1;
	logic [15:0]        tu_s1;
	logic [15:0]        phi_s1;
	logic [31:0]        fy_s1;
	logic [41:0]        dd_s1;
	logic signed [21:0] dev;
	logic signed [43:0] dev_sq;

	assign dev    = $signed({2'b0, equiv_ratio, 4'b0}) - 22'sd70451;
	assign dev_sq = 44'(dev) * 44'(dev);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1   <= pressure;
			tu_s1  <= unburnt_temp;
			phi_s1 <= equiv_ratio;
			fy_s1  <= 32'(residual_factor_q) * 32'(residual_frac);
			dd_s1  <= dev_sq[41:0];
		end
	end

	// special cases
	flsp_pkg::spec_t spec_c;
	flsp_pkg::spec_t spec_s2, spec_s3, spec_s4, spec_s5, spec_s6, spec_s7;

	always_comb begin
		spec_c.tu_skip = (tu_s1 == 16'd0);
		spec_c.p_skip  = (p_s1 == 24'd0);
		spec_c.zero    = (phi_s1 == 16'd0) || (ref_speed_q == 24'd0)
			|| (fy_s1 >= 32'h1000_0000)
			|| (spec_c.tu_skip && temp_exponent_q > 16'sd0)
			|| (spec_c.p_skip && press_exponent_q > 16'sd0);
		spec_c.inf     = (spec_c.tu_skip && temp_exponent_q < 16'sd0)
			|| (spec_c.p_skip && press_exponent_q < 16'sd0);
	end

	// log units: two stages each, results valid at stage 3
	logic signed [31:0] lw_s3, lphi_s3, ltu_s3, lp_s3, lres_s3;
	logic [28:0]        res_op;

	assign res_op = 29'h1000_0000 - fy_s1[28:0];

	flsp_log2 #(.B(LOG_TABLE_BITS), .W_IN(24), .Q(16)) u_log_w (
		.clk(clk), .en(en), .v(ref_speed_q), .log_s2(lw_s3));
	flsp_log2 #(.B(LOG_TABLE_BITS), .W_IN(16), .Q(12)) u_log_phi (
		.clk(clk), .en(en), .v(phi_s1), .log_s2(lphi_s3));
	flsp_log2 #(.B(LOG_TABLE_BITS), .W_IN(16), .Q(4)) u_log_tu (
		.clk(clk), .en(en), .v(tu_s1), .log_s2(ltu_s3));
	flsp_log2 #(.B(LOG_TABLE_BITS), .W_IN(24), .Q(0)) u_log_p (
		.clk(clk), .en(en), .v(p_s1), .log_s2(lp_s3));
	flsp_log2 #(.B(LOG_TABLE_BITS), .W_IN(29), .Q(28)) u_log_res (
		.clk(clk), .en(en), .v(res_op), .log_s2(lres_s3));

	// stages 2-3: gaussian term in log2 units
	logic signed [40:0] t_prod;
	logic signed [32:0] t_s2;
	logic signed [64:0] g_prod;
	logic signed [35:0] g_s3;

	assign t_prod = 41'(gauss_width_q) * $signed({17'b0, dd_s1[39:16]});
	assign g_prod = 65'(t_s2) * 65'(flsp_pkg::LOG2E_Q30);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s2    <= 33'(t_prod >>> 8);
			spec_s2 <= spec_c;
			g_s3    <= 36'(g_prod >>> 30);
			spec_s3 <= spec_s2;
		end
	end

	// stage 4: scale each log by its exponent
	logic signed [47:0] phi_prod;
	logic signed [32:0] tu_diff, p_diff;
	logic signed [48:0] tu_prod, p_prod;
	logic signed [39:0] lw_s4, phi_t_s4, g_s4, tu_t_s4, p_t_s4, lres_s4;

	assign phi_prod = 48'(phi_exponent_q) * 48'(lphi_s3);
	assign tu_diff  = 33'(ltu_s3) - 33'(LOG_4800);
	assign p_diff   = 33'(lp_s3) - 33'(LOG_101300);
	assign tu_prod  = 49'(temp_exponent_q) * 49'(tu_diff);
	assign p_prod   = 49'(press_exponent_q) * 49'(p_diff);

	always_ff @(posedge clk) begin
		if (en) begin
			lw_s4    <= 40'(lw_s3);
			phi_t_s4 <= 40'(phi_prod >>> 12);
			g_s4     <= 40'(g_s3);
			tu_t_s4  <= spec_s3.tu_skip ? 40'sd0 : 40'(tu_prod >>> 12);
			p_t_s4   <= spec_s3.p_skip ? 40'sd0 : 40'(p_prod >>> 12);
			lres_s4  <= 40'(lres_s3);
			spec_s4  <= spec_s3;
		end
	end

	// stage 5: sum the log terms, offset to Q16 output
	logic signed [41:0] e_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			e_s5 <= 42'(lw_s4) + 42'(phi_t_s4) - 42'(g_s4) + 42'(tu_t_s4)
				+ 42'(p_t_s4) + 42'(lres_s4) + 42'(16 << flsp_pkg::LOG_FRAC_BITS);
			spec_s5 <= spec_s4;
		end
	end

	// stages 6-7: exp2 mantissa
	logic [31:0]        m_s7;
	logic signed [21:0] ip_s7;

	flsp_exp2 #(.B(LOG_TABLE_BITS)) u_exp (
		.clk(clk), .en(en), .e(e_s5), .m_s2(m_s7), .ip_s2(ip_s7));

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s6 <= spec_s5;
			spec_s7 <= spec_s6;
		end
	end

	// stage 8: round, shift, saturate
	logic [23:0] speed_c;
	logic        sat_c;
	logic [5:0]  sh_amt;
	logic [32:0] rsum;
	logic [32:0] rval;
	logic [23:0] speed_s8;
	logic        sat_s8;

	always_comb begin
		speed_c = '0;
		sat_c   = 1'b0;
		sh_amt  = 6'(30 - int'(ip_s7));
		rsum    = {1'b0, m_s7} + (33'd1 << (sh_amt - 6'd1));
		rval    = rsum >> sh_amt;
		if (spec_s7.zero) begin
			speed_c = '0;
		end else if (spec_s7.inf || ip_s7 >= 22'sd24) begin
			speed_c = flsp_pkg::SPEED_MAX;
			sat_c   = 1'b1;
		end else if (ip_s7 < -22'sd2) begin
			speed_c = '0;
		end else if (rval > 33'(flsp_pkg::SPEED_MAX)) begin
			speed_c = flsp_pkg::SPEED_MAX;
			sat_c   = 1'b1;
		end else begin
			speed_c = rval[23:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			speed_s8 <= speed_c;
			sat_s8   <= sat_c;
		end
	end

	assign out_valid   = vld_s8;
	assign flame_speed = speed_s8;
	assign saturated   = sat_s8;

	// checks
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> flame_speed == flsp_pkg::SPEED_MAX)
		else $error("saturated result not at maximum");

	a_zero_case: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 && en && spec_s7.zero |=> flame_speed == 24'd0 && !saturated)
		else $error("zero special case not honored");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s1)
		else $error("accepted request lost at stage 1");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(vld_s1) && $stable(vld_s7))
		else $error("pipeline moved during stall");

endmodule

/* bench/flame_speed_checker.sv */
`timescale 1ns / 1ps
module flame_speed_checker #(
	parameter int LOG_TABLE_BITS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [23:0] pressure,
	input  logic [15:0] unburnt_temp,
	input  logic [15:0] equiv_ratio,
	input  logic [15:0] residual_frac,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [23:0] flame_speed,
	input  logic        saturated,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	localparam int TN = (1 << LOG_TABLE_BITS);
	localparam int SH_LOG = 32 - LOG_TABLE_BITS;
	localparam int SH_EXP = 20 - LOG_TABLE_BITS;

	typedef struct packed {
		logic [23:0] speed;
		logic        sat;
	} speed_t;

	speed_t speed_q[$];
	longint unsigned log_tab [0:TN];
	longint unsigned exp_tab [0:TN];

	logic [23:0] w_reg;
	logic signed [15:0] eta_reg, xi_reg, alpha_reg, beta_reg;
	logic [15:0] f_reg;

	function automatic longint fl_shr(longint x, int s);
		return x >>> s;
	endfunction

	// log2 in Q20 of a nonzero value with q fraction bits
	function automatic longint log2_q20(longint unsigned v, int q);
		int n;
		longint unsigned u, idx, rem, d;
		n = 63;
		while (((v >> n) & 64'd1) == 0) n--;
		if (n >= 32) u = (v >> (n - 32)) & 64'hFFFF_FFFF;
		else u = (v << (32 - n)) & 64'hFFFF_FFFF;
		idx = u >> SH_LOG;
		rem = u & ((64'd1 << SH_LOG) - 1);
		d = log_tab[idx + 1] - log_tab[idx];
		return longint'(n - q) * (64'sd1 << 20) + longint'(log_tab[idx] + ((d * rem) >> SH_LOG));
	endfunction

	function automatic speed_t flame_speed_of(logic [23:0] p, logic [15:0] tu,
			logic [15:0] phi, logic [15:0] y);
		speed_t res;
		longint unsigned fy, m, jj, r, spd;
		longint lsum, e, ip, fr, d, sq, t, s;
		res = '0;
		fy = longint'(f_reg) * longint'(y);
		if (phi == 0 || w_reg == 0 || fy >= (64'd1 << 28) ||
				(tu == 0 && alpha_reg > 0) || (p == 0 && beta_reg > 0)) begin
			return res;
		end
		if ((tu == 0 && alpha_reg < 0) || (p == 0 && beta_reg < 0)) begin
			res.speed = flsp_pkg::SPEED_MAX;
			res.sat = 1'b1;
			return res;
		end
		lsum = log2_q20(w_reg, 16);
		lsum += fl_shr(longint'(eta_reg) * log2_q20(phi, 12), 12);
		d = longint'(phi) * 16 - flsp_pkg::PHI_CENTER_Q16;
		sq = longint'(longint'(unsigned'(d * d)) >> 16);
		t = fl_shr(longint'(xi_reg) * sq, 8);
		lsum -= fl_shr(t * flsp_pkg::LOG2E_Q30, 30);
		if (tu != 0)
			lsum += fl_shr(longint'(alpha_reg) * (log2_q20(tu, 4) - log2_q20(4800, 4)), 12);
		if (p != 0)
			lsum += fl_shr(longint'(beta_reg) * (log2_q20(p, 0) - log2_q20(101300, 0)), 12);
		lsum += log2_q20((64'd1 << 28) - fy, 28);
		e = lsum + 16 * (64'sd1 << 20);
		if (e >= 24 * (64'sd1 << 20)) begin
			res.speed = flsp_pkg::SPEED_MAX;
			res.sat = 1'b1;
			return res;
		end
		ip = fl_shr(e, 20);
		fr = e - ip * (64'sd1 << 20);
		jj = longint'(fr) >> SH_EXP;
		r = longint'(fr) & ((64'd1 << SH_EXP) - 1);
		m = exp_tab[jj] + (((exp_tab[jj + 1] - exp_tab[jj]) * r) >> SH_EXP);
		s = 30 - ip;
		if (s >= 62) spd = 0;
		else spd = (m + (64'd1 << (s - 1))) >> s;
		if (spd > flsp_pkg::SPEED_MAX) begin
			res.speed = flsp_pkg::SPEED_MAX;
			res.sat = 1'b1;
		end else begin
			res.speed = spd[23:0];
		end
		return res;
	endfunction

	// build both tables independently of the package helpers
	initial begin
		longint unsigned roots [0:LOG_TABLE_BITS];
		longint unsigned x, k, m;
		roots[0] = 64'd1 << 31;
		for (int j = 1; j <= LOG_TABLE_BITS; j++) begin
			longint unsigned v, rs, b;
			v = roots[j-1] << 30;
			rs = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= rs + b) begin
					v -= rs + b;
					rs = (rs >> 1) + b;
				end else begin
					rs >>= 1;
				end
				b >>= 2;
			end
			roots[j] = rs;
		end
		for (int i = 0; i < TN; i++) begin
			x = (64'd1 << 30) + (longint'(i) << (30 - LOG_TABLE_BITS));
			k = 0;
			m = 64'd1 << 30;
			for (int j = 0; j <= 20; j++) begin
				x = (x * x) >> 30;
				k <<= 1;
				if (x >= (64'd1 << 31)) begin
					x >>= 1;
					k |= 1;
				end
			end
			log_tab[i] = (k + 1) >> 1;
			for (int j = 0; j < LOG_TABLE_BITS; j++)
				if (((i >> j) & 1) != 0)
					m = (m * roots[LOG_TABLE_BITS - j] + (64'd1 << 29)) >> 30;
			exp_tab[i] = m;
		end
		log_tab[TN] = 64'd1 << 20;
		exp_tab[TN] = 64'd1 << 31;
	end

	// track registers, predict accepted requests, compare results
	always @(posedge clk or negedge arst_n) begin
		speed_t exp_r;
		if (!arst_n) begin
			w_reg <= 24'd65536;
			eta_reg <= 16'sd4096;
			xi_reg <= 16'sd4096;
			f_reg <= 16'd0;
			alpha_reg <= 16'sd8192;
			beta_reg <= 16'sd0;
			fail_count <= 0;
			pending <= 0;
			speed_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					flsp_pkg::REG_REF_SPEED: w_reg <= cfg_data;
					flsp_pkg::REG_PHI_EXP: eta_reg <= cfg_data[15:0];
					flsp_pkg::REG_GAUSS: xi_reg <= cfg_data[15:0];
					flsp_pkg::REG_RESIDUAL: f_reg <= cfg_data[15:0];
					flsp_pkg::REG_TEMP_EXP: alpha_reg <= cfg_data[15:0];
					flsp_pkg::REG_PRESS_EXP: beta_reg <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				speed_q.push_back(flame_speed_of(pressure, unburnt_temp, equiv_ratio,
					residual_frac));
			if (out_valid && out_ready) begin
				if (speed_q.size() == 0) begin
					$display("%0t: unexpected result speed=%h sat=%b", $time,
						flame_speed, saturated);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = speed_q.pop_front();
					if (exp_r.speed !== flame_speed || exp_r.sat !== saturated) begin
						$display("%0t: mismatch expected speed=%h sat=%b actual speed=%h sat=%b",
							$time, exp_r.speed, exp_r.sat, flame_speed, saturated);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= speed_q.size();
		end
	end
endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
module tb;

	logic        clk, arst_n;
	logic        in_valid, in_ready, out_valid, out_ready, saturated, cfg_we;
	logic [23:0] pressure, flame_speed, cfg_data;
	logic [15:0] unburnt_temp, equiv_ratio, residual_frac;
	logic [2:0]  cfg_index;
	int          fail_count, pending;
	bit          stall_mode;

	laminar_flame_speed_eval_core dut (.*);
	flame_speed_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// receiver stall pattern: phases of no stall and phases of heavy stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_mode = 1'b0;
			out_ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 199) == 0) stall_mode = ~stall_mode;
			out_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
		end
	end

	task automatic send_request(logic [23:0] p, logic [15:0] tu, logic [15:0] phi,
			logic [15:0] y);
		in_valid <= 1'b1;
		pressure <= p;
		unburnt_temp <= tu;
		equiv_ratio <= phi;
		residual_frac <= y;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic idle_gap(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		idle_gap(1);
		while (pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// realistic-ish request, sometimes with wild fields
	task automatic random_request();
		logic [23:0] p;
		logic [15:0] tu, phi, y;
		if ($urandom_range(0, 3) == 0) begin
			p = 24'($urandom);
			tu = 16'($urandom);
			phi = 16'($urandom);
			y = 16'($urandom);
		end else begin
			p = 24'($urandom_range(10000, 8000000));
			tu = 16'($urandom_range(3200, 16000));
			phi = 16'($urandom_range(1500, 7000));
			y = 16'($urandom_range(0, 20000));
		end
		send_request(p, tu, phi, y);
	endtask

	initial begin
		int burst;
		arst_n = 1'b0;
		in_valid = 1'b0;
		pressure = '0;
		unburnt_temp = '0;
		equiv_ratio = '0;
		residual_frac = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults, then zero/infinite cases and field extremes
		send_request(24'd101300, 16'd4800, 16'd4096, 16'd0);
		send_request(24'd101300, 16'd4800, 16'd0, 16'd0);
		send_request(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_request(24'd1, 16'd1, 16'd1, 16'd1);
		send_request(24'd0, 16'd0, 16'd4096, 16'd0);
		drain();
		write_reg(flsp_pkg::REG_TEMP_EXP, 24'h00E000);
		write_reg(flsp_pkg::REG_PRESS_EXP, 24'h00F000);
		write_reg(flsp_pkg::REG_RESIDUAL, 24'h00FFFF);
		send_request(24'd0, 16'd4800, 16'd4096, 16'd0);
		send_request(24'd101300, 16'd0, 16'd4096, 16'd0);
		send_request(24'd101300, 16'd4800, 16'd4096, 16'd4097);
		send_request(24'd101300, 16'd4800, 16'd4096, 16'd4096);
		send_request(24'd101300, 16'd4800, 16'd4096, 16'd4095);
		send_request(24'd500000, 16'd9000, 16'd4403, 16'd1000);
		drain();
		write_reg(flsp_pkg::REG_REF_SPEED, 24'hFFFFFF);
		write_reg(flsp_pkg::REG_PHI_EXP, 24'h007FFF);
		write_reg(flsp_pkg::REG_GAUSS, 24'h008000);
		write_reg(flsp_pkg::REG_TEMP_EXP, 24'h007FFF);
		write_reg(flsp_pkg::REG_PRESS_EXP, 24'h007FFF);
		write_reg(flsp_pkg::REG_RESIDUAL, 24'h000000);
		write_reg(3'd7, 24'h123456);
		send_request(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
		send_request(24'd1, 16'd1, 16'd1, 16'd0);
		send_request(24'd0, 16'd100, 16'd4096, 16'd0);
		send_request(24'd101300, 16'd4800, 16'd4096, 16'd0);
		drain();
		write_reg(flsp_pkg::REG_REF_SPEED, 24'd0);
		send_request(24'd101300, 16'd4800, 16'd4096, 16'd0);
		drain();

		// random phases, each with a fresh register setting
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 0) begin
				write_reg(flsp_pkg::REG_REF_SPEED, 24'd26214);
				write_reg(flsp_pkg::REG_PHI_EXP, 24'd1000);
				write_reg(flsp_pkg::REG_GAUSS, 24'd20000);
				write_reg(flsp_pkg::REG_RESIDUAL, 24'd9000);
				write_reg(flsp_pkg::REG_TEMP_EXP, 24'd8000);
				write_reg(flsp_pkg::REG_PRESS_EXP, 24'hFFFF & -24'd1200);
			end else begin
				write_reg(flsp_pkg::REG_REF_SPEED, (ph == 7) ? 24'hFFFFFF : 24'($urandom));
				write_reg(flsp_pkg::REG_PHI_EXP, $urandom_range(0, 1) ? 24'($urandom)
					: 24'($urandom_range(0, 8000)));
				write_reg(flsp_pkg::REG_GAUSS, $urandom_range(0, 1) ? 24'($urandom)
					: 24'($urandom_range(0, 30000)));
				write_reg(flsp_pkg::REG_RESIDUAL, 24'($urandom));
				write_reg(flsp_pkg::REG_TEMP_EXP, 24'($urandom));
				write_reg(flsp_pkg::REG_PRESS_EXP, 24'($urandom));
			end
			for (int n = 0; n < 215; n += burst) begin
				burst = $urandom_range(1, 30);
				for (int b = 0; b < burst; b++) random_request();
				if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
			end
			drain();
		end

		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
